// ===== src/oopd_pkg.sv =====
// Package for the out-of-place n-gram distance block: widths, limits,
// command/status structs shared by controller and datapath, key forming.
// No dependencies.
`default_nettype none

package oopd_pkg;

   localparam int TABLE_DEPTH  = 512;
   localparam int MAX_GRAM_LEN = 5;

   localparam int GRAM_W      = 40;
   localparam int GRAM_BYTES  = 5;
   localparam int LEN_W       = 3;
   localparam int KEY_W       = LEN_W + GRAM_W;
   localparam int ENTRY_W     = KEY_W + 1;
   localparam int KEY_LEN_LIM = (MAX_GRAM_LEN < GRAM_BYTES) ? MAX_GRAM_LEN : GRAM_BYTES;

   localparam int ADDR_W = $clog2(TABLE_DEPTH);
   localparam int FILL_W = $clog2(TABLE_DEPTH + 1);

   localparam int PLEN_W = 10;
   localparam logic [PLEN_W-1:0] PLEN_RESET = 10'd400;

   localparam int POS_W = 10;
   localparam logic [POS_W-1:0] CNT_MAX = 10'd1023;

   localparam int SUM_W  = 20;
   localparam int SUMX_W = SUM_W + 1;
   localparam logic [SUM_W-1:0] SUM_MAX = 20'hFFFFF;

   localparam int DIFF_W = (ADDR_W > POS_W) ? ADDR_W : POS_W;
   localparam int CMP_W  = (FILL_W > PLEN_W) ? FILL_W : PLEN_W;

   localparam logic OP_LOAD    = 1'b0;
   localparam logic OP_MEASURE = 1'b1;

   typedef struct packed {
      logic accept;
      logic ram_rd;
      logic wr_inval;
      logic wr_new;
      logic capture;
      logic found;
      logic acc;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic op;
      logic last;
      logic load_full;
      logic scan_more;
      logic hit;
      logic rsp_busy;
   } sts_type;

   // key = {clamped length, gram with bytes past the length cleared}
   function automatic logic [KEY_W-1:0] form_key(input logic [GRAM_W-1:0] gram,
                                                 input logic [LEN_W-1:0] len);
      logic [LEN_W-1:0]  n;
      logic [GRAM_W-1:0] masked;
      n = (len > LEN_W'(KEY_LEN_LIM)) ? LEN_W'(KEY_LEN_LIM) : len;
      for (int b = 0; b < GRAM_BYTES; b++) begin
         masked[b*8 +: 8] = (LEN_W'(b) < n) ? gram[b*8 +: 8] : 8'h00;
      end
      return {n, masked};
   endfunction

endpackage

`default_nettype wire

// ===== src/oopd_if.sv =====
// Handshake channels of the out-of-place distance block: key input,
// distance result and profile length write. Uses oopd_pkg.
`default_nettype none

interface oopd_req_if;
   logic                       valid;
   logic                       ready;
   logic                       op;
   logic [oopd_pkg::GRAM_W-1:0] gram;
   logic [oopd_pkg::LEN_W-1:0]  gram_len;
   logic                       first;
   logic                       last;
   modport source (output valid, op, gram, gram_len, first, last, input ready);
   modport sink   (input valid, op, gram, gram_len, first, last, output ready);
endinterface

interface oopd_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [oopd_pkg::SUM_W-1:0]  distance;
   logic [oopd_pkg::POS_W-1:0]  miss_count;
   modport source (output valid, distance, miss_count, input ready);
   modport sink   (input valid, distance, miss_count, output ready);
endinterface

interface oopd_csr_if;
   logic                        valid;
   logic                        ready;
   logic [oopd_pkg::PLEN_W-1:0] profile_length;
   modport source (output valid, profile_length, input ready);
   modport sink   (input valid, profile_length, output ready);
endinterface

`default_nettype wire

// ===== src/oopd_ram.sv =====
// Generic single-port RAM with registered read; write has priority.
// No dependencies.
`default_nettype none

module oopd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     en,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] addr,
   input  wire logic [WIDTH-1:0]         wdata,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         if (we) begin
            mem_ff[addr] <= wdata;
         end else begin
            rdata_ff <= mem_ff[addr];
         end
      end
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

// ===== src/oopd_ctrl.sv =====
// Sequencer of the out-of-place distance block: accept, table scan,
// invalidate/write on load, accumulate and emit on measure. Uses oopd_pkg.
`default_nettype none

module oopd_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire oopd_pkg::sts_type sts,
   output oopd_pkg::cmd_type      cmd
);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_SCAN  = 3'd1;
   localparam logic [2:0] S_INVAL = 3'd2;
   localparam logic [2:0] S_WRITE = 3'd3;
   localparam logic [2:0] S_ACC   = 3'd4;
   localparam logic [2:0] S_EMIT  = 3'd5;

   logic [2:0] state_ff, state_in;
   logic       pend_ff, pend_in;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      pend_in  = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = S_SCAN;
            end
         end
         S_SCAN: begin
            priority if (sts.op == oopd_pkg::OP_LOAD && sts.load_full) begin
               state_in = S_IDLE;
            end else if (pend_ff && sts.hit) begin
               if (sts.op == oopd_pkg::OP_LOAD) begin
                  state_in = S_INVAL;
               end else begin
                  cmd.capture = 1'b1;
                  cmd.found   = 1'b1;
                  state_in    = S_ACC;
               end
            end else if (sts.scan_more) begin
               cmd.ram_rd = 1'b1;
               pend_in    = 1'b1;
            end else begin
               if (sts.op == oopd_pkg::OP_LOAD) begin
                  state_in = S_WRITE;
               end else begin
                  cmd.capture = 1'b1;
                  state_in    = S_ACC;
               end
            end
         end
         S_INVAL: begin
            cmd.wr_inval = 1'b1;
            state_in     = S_WRITE;
         end
         S_WRITE: begin
            cmd.wr_new = 1'b1;
            state_in   = S_IDLE;
         end
         S_ACC: begin
            cmd.acc  = 1'b1;
            state_in = sts.last ? S_EMIT : S_IDLE;
         end
         S_EMIT: begin
            if (!sts.rsp_busy) begin
               cmd.emit = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         pend_ff  <= pend_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);

   a_accept_scan: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE && req_valid) |=> state_ff == S_SCAN)
      else $error("accepted item did not start a scan");

   a_ram_excl: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.ram_rd, cmd.wr_inval, cmd.wr_new}))
      else $error("more than one table access in a cycle");

   a_write_from: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_WRITE |-> ($past(state_ff) == S_SCAN || $past(state_ff) == S_INVAL))
      else $error("table write not preceded by a scan");

   a_emit_from: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_EMIT |-> ($past(state_ff) == S_ACC || $past(state_ff) == S_EMIT))
      else $error("result emitted without accumulation");

   a_pend_scan: assert property (@(posedge clock) disable iff (reset)
      pend_ff |-> state_ff == S_SCAN)
      else $error("read pending outside a scan");

endmodule

`default_nettype wire

// ===== src/oopd_dp.sv =====
// Datapath of the out-of-place distance block: reference table RAM, fill
// count, scan pointer, accumulators, result register. Uses oopd_pkg, oopd_ram.
`default_nettype none

module oopd_dp (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire oopd_pkg::cmd_type           cmd,
   output oopd_pkg::sts_type                sts,
   input  wire logic                        req_op,
   input  wire logic [oopd_pkg::GRAM_W-1:0] req_gram,
   input  wire logic [oopd_pkg::LEN_W-1:0]  req_gram_len,
   input  wire logic                        req_first,
   input  wire logic                        req_last,
   oopd_rsp_if.source                       rsp,
   oopd_csr_if.sink                         csr
);

   logic [oopd_pkg::KEY_W-1:0]   key_ff;
   logic                         op_ff, last_ff;
   logic [oopd_pkg::FILL_W-1:0]  fill_ff;
   logic [oopd_pkg::FILL_W-1:0]  addr_ff;
   logic [oopd_pkg::ADDR_W-1:0]  idx_ff;
   logic [oopd_pkg::ADDR_W-1:0]  rank_ff;
   logic                         hit_ff;
   logic [oopd_pkg::POS_W-1:0]   mpos_ff;
   logic [oopd_pkg::POS_W-1:0]   miss_ff;
   logic [oopd_pkg::SUM_W-1:0]   sum_ff;
   logic [oopd_pkg::PLEN_W-1:0]  plen_ff;
   logic                         rsp_valid_ff;
   logic [oopd_pkg::SUM_W-1:0]   dist_out_ff;
   logic [oopd_pkg::POS_W-1:0]   miss_out_ff;

   logic                         ram_en;
   logic [oopd_pkg::ADDR_W-1:0]  ram_addr;
   logic [oopd_pkg::ENTRY_W-1:0] ram_wdata, ram_rdata;

   logic [oopd_pkg::CMP_W-1:0]   fill_x, plen_x;
   logic [oopd_pkg::DIFF_W-1:0]  pos_x, rank_x, diff;
   logic [oopd_pkg::SUMX_W-1:0]  add_x, sum_x;

   assign ram_en    = cmd.ram_rd | cmd.wr_inval | cmd.wr_new;
   assign ram_wdata = {cmd.wr_new, key_ff};

   always_comb begin
      priority if (cmd.wr_new) begin
         ram_addr = fill_ff[oopd_pkg::ADDR_W-1:0];
      end else if (cmd.wr_inval) begin
         ram_addr = idx_ff;
      end else begin
         ram_addr = addr_ff[oopd_pkg::ADDR_W-1:0];
      end
   end

   oopd_ram #(
      .WIDTH (oopd_pkg::ENTRY_W),
      .DEPTH (oopd_pkg::TABLE_DEPTH)
   ) u_table (
      .clock (clock),
      .en    (ram_en),
      .we    (cmd.wr_inval | cmd.wr_new),
      .addr  (ram_addr),
      .wdata (ram_wdata),
      .rdata (ram_rdata)
   );

   assign fill_x = oopd_pkg::CMP_W'(fill_ff);
   assign plen_x = oopd_pkg::CMP_W'(plen_ff);

   assign sts.op        = op_ff;
   assign sts.last      = last_ff;
   assign sts.load_full = (fill_x >= plen_x) ||
                          (fill_x >= oopd_pkg::CMP_W'(oopd_pkg::TABLE_DEPTH));
   assign sts.scan_more = addr_ff < fill_ff;
   assign sts.hit       = ram_rdata[oopd_pkg::ENTRY_W-1] &&
                          (ram_rdata[oopd_pkg::KEY_W-1:0] == key_ff);
   assign sts.rsp_busy  = rsp_valid_ff && !rsp.ready;

   assign pos_x  = oopd_pkg::DIFF_W'(mpos_ff);
   assign rank_x = oopd_pkg::DIFF_W'(rank_ff);
   assign diff   = (pos_x >= rank_x) ? (pos_x - rank_x) : (rank_x - pos_x);
   assign add_x  = hit_ff ? oopd_pkg::SUMX_W'(diff) : oopd_pkg::SUMX_W'(plen_ff);
   assign sum_x  = {1'b0, sum_ff} + add_x;

   // item fields, read index, match rank and result register
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         key_ff  <= oopd_pkg::form_key(req_gram, req_gram_len);
         op_ff   <= req_op;
         last_ff <= req_last;
      end
      if (cmd.ram_rd) begin
         idx_ff <= addr_ff[oopd_pkg::ADDR_W-1:0];
      end
      if (cmd.capture) begin
         hit_ff  <= cmd.found;
         rank_ff <= idx_ff;
      end
      if (cmd.emit) begin
         dist_out_ff <= sum_ff;
         miss_out_ff <= miss_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         addr_ff      <= '0;
         fill_ff      <= '0;
         mpos_ff      <= '0;
         miss_ff      <= '0;
         sum_ff       <= '0;
         plen_ff      <= oopd_pkg::PLEN_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr.valid) begin
            plen_ff <= csr.profile_length;
         end
         if (cmd.accept) begin
            addr_ff <= '0;
            if (req_first) begin
               if (req_op == oopd_pkg::OP_LOAD) begin
                  fill_ff <= '0;
               end else begin
                  mpos_ff <= '0;
                  miss_ff <= '0;
                  sum_ff  <= '0;
               end
            end
         end else if (cmd.ram_rd) begin
            addr_ff <= addr_ff + 1'b1;
         end
         if (cmd.wr_new) begin
            fill_ff <= fill_ff + 1'b1;
         end
         if (cmd.acc) begin
            sum_ff <= (sum_x > oopd_pkg::SUMX_W'(oopd_pkg::SUM_MAX)) ?
                      oopd_pkg::SUM_MAX : sum_x[oopd_pkg::SUM_W-1:0];
            if (!hit_ff && miss_ff != oopd_pkg::CNT_MAX) begin
               miss_ff <= miss_ff + 1'b1;
            end
            if (mpos_ff != oopd_pkg::CNT_MAX) begin
               mpos_ff <= mpos_ff + 1'b1;
            end
         end
         if (cmd.emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign csr.ready      = 1'b1;
   assign rsp.valid      = rsp_valid_ff;
   assign rsp.distance   = dist_out_ff;
   assign rsp.miss_count = miss_out_ff;

endmodule

`default_nettype wire

// ===== src/ngram_out_of_place_distance.sv =====
// Out-of-place n-gram distance, one item at a time. With fill loaded entries
// (at most TABLE_DEPTH), a load item scans them, invalidates a repeated key
// and writes its key, or is dropped once fill reaches the profile length or
// TABLE_DEPTH; a measure item scans too, a hit ends its scan early, and last
// adds an emit state that waits on any held result.
// Synchronous active-high reset empties the table at once (fill count to zero).
`default_nettype none

module ngram_out_of_place_distance (
   input wire logic   clock,
   input wire logic   reset,
   oopd_req_if.sink   req_ch,
   oopd_rsp_if.source rsp_ch,
   oopd_csr_if.sink   csr_ch
);

   oopd_pkg::cmd_type cmd;
   oopd_pkg::sts_type sts;

   oopd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   oopd_dp u_dp (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .sts          (sts),
      .req_op       (req_ch.op),
      .req_gram     (req_ch.gram),
      .req_gram_len (req_ch.gram_len),
      .req_first    (req_ch.first),
      .req_last     (req_ch.last),
      .rsp          (rsp_ch),
      .csr          (csr_ch)
   );

endmodule

`default_nettype wire
